[design/obb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants for the oriented box face axis overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int IN_BITS       = 32;
   localparam int NUM_SLOTS     = 10;
   localparam int NUM_AXES      = 6;
   localparam int SLOT_BITS     = 4;
   localparam int AXIS_BITS     = 3;

   localparam logic [SLOT_BITS-1:0] SLOT_CENTER_A = 4'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_CENTER_B = 4'd5;
   localparam logic [SLOT_BITS-1:0] SLOT_AXIS_A   = 4'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_EXT_A    = 4'd4;
   localparam logic [SLOT_BITS-1:0] SLOT_AXIS_B   = 4'd6;
   localparam logic [SLOT_BITS-1:0] SLOT_EXT_B    = 4'd9;

endpackage

`default_nettype wire

[design/obb_row_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obb_row_store
// Ten-row vector store with one write port, two registered read ports and
// a valid bit per row so that unwritten rows read as zero.
// ----------------------------------------------------------------------------
module obb_row_store #(
   parameter int WORD_BITS = obb_pkg::WORD_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           wr_en,
   input  wire [obb_pkg::SLOT_BITS-1:0]  wr_addr,
   input  wire [3*WORD_BITS-1:0]         wr_data,
   input  wire [obb_pkg::SLOT_BITS-1:0]  rd_addr_a,
   input  wire [obb_pkg::SLOT_BITS-1:0]  rd_addr_b,
   output logic [3*WORD_BITS-1:0]        rd_data_a,
   output logic [3*WORD_BITS-1:0]        rd_data_b
);

   logic [3*WORD_BITS-1:0]         mem [obb_pkg::NUM_SLOTS];
   logic [obb_pkg::NUM_SLOTS-1:0]  valid_ff;
   logic [3*WORD_BITS-1:0]         rd_a_ff;
   logic [3*WORD_BITS-1:0]         rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
      rd_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[design/obb_fx_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obb_fx_mul
// Shared fixed-point multiplier. The exact magnitude product is registered,
// then rounded half away from zero, scaled and saturated to the word range.
// ----------------------------------------------------------------------------
module obb_fx_mul #(
   parameter int WORD_BITS = obb_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire signed [WORD_BITS-1:0]   op_a,
   input  wire signed [WORD_BITS-1:0]   op_b,
   output logic signed [WORD_BITS-1:0]  result
);

   localparam int PW = 2 * WORD_BITS + 1;

   logic [WORD_BITS-1:0]    mag_a;
   logic [WORD_BITS-1:0]    mag_b;
   logic [2*WORD_BITS-1:0]  prod_ff;
   logic                    neg_ff;
   logic [PW-1:0]           rounded;
   logic [PW-1:0]           limit;
   logic [PW-1:0]           clamped;

   assign mag_a = op_a[WORD_BITS-1] ? WORD_BITS'(-op_a) : WORD_BITS'(op_a);
   assign mag_b = op_b[WORD_BITS-1] ? WORD_BITS'(-op_b) : WORD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= (2*WORD_BITS)'(mag_a) * (2*WORD_BITS)'(mag_b);
      neg_ff  <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
   end

   always_comb begin
      rounded = ({1'b0, prod_ff} + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      limit   = neg_ff ? (PW'(1) << (WORD_BITS - 1))
                       : ((PW'(1) << (WORD_BITS - 1)) - PW'(1));
      clamped = (rounded > limit) ? limit : rounded;
      result  = neg_ff ? -signed'(clamped[WORD_BITS-1:0])
                       : signed'(clamped[WORD_BITS-1:0]);
   end

endmodule

`default_nettype wire

[design/obb_face_axis_overlap_test_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obb_face_axis_overlap_test_top
// Loads two oriented boxes one vector per transaction and runs the
// separating-axis test on the six face axes with one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | slot, vec_x, vec_y, vec_z, last
//  rsp     | out       | rsp_valid / rsp_stall  | overlap, separating_axis
//
// A vector transaction without last only writes its row. With last, it also
// starts the test: for each axis until one separates, 36 radius and 3 center
// multiplies, each through the shared multiplier in a multiply and a write-back state.
// Reset clears the store to zero through per-row valid bits.
// req_stall is high while the test runs; a result waits for rsp_stall.
// ----------------------------------------------------------------------------
module obb_face_axis_overlap_test_top #(
   parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = obb_pkg::WORD_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [obb_pkg::SLOT_BITS-1:0]        req_slot,
   input  wire signed [obb_pkg::IN_BITS-1:0]   req_vec_x,
   input  wire signed [obb_pkg::IN_BITS-1:0]   req_vec_y,
   input  wire signed [obb_pkg::IN_BITS-1:0]   req_vec_z,
   input  wire                                 req_last,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_overlap,
   output logic [obb_pkg::AXIS_BITS-1:0]       rsp_separating_axis
);

   localparam int W  = WORD_BITS;
   localparam int XB = (W > obb_pkg::IN_BITS) ? W + 1 : obb_pkg::IN_BITS + 1;
   localparam logic signed [W-1:0] WMAX = W'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [W-1:0] WMIN = -WMAX - W'(1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDDIFF = 4'd1;
   localparam logic [3:0] S_DIFF   = 4'd2;
   localparam logic [3:0] S_RDL    = 4'd3;
   localparam logic [3:0] S_LATL   = 4'd4;
   localparam logic [3:0] S_RDT    = 4'd5;
   localparam logic [3:0] S_LATT   = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_WB     = 4'd8;
   localparam logic [3:0] S_ACC    = 4'd9;
   localparam logic [3:0] S_CMP    = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   localparam logic [1:0] PH_SCALE = 2'd0;
   localparam logic [1:0] PH_DOT   = 2'd1;
   localparam logic [1:0] PH_DIFF  = 2'd2;

   localparam logic [obb_pkg::AXIS_BITS-1:0] AXIS_NONE =
      obb_pkg::AXIS_BITS'(obb_pkg::NUM_AXES);
   localparam logic [obb_pkg::AXIS_BITS-1:0] AXIS_LAST =
      obb_pkg::AXIS_BITS'(obb_pkg::NUM_AXES - 1);

   function automatic logic signed [W-1:0] load_word(input logic [obb_pkg::IN_BITS-1:0] raw);
      logic signed [XB-1:0] v;
      v = XB'(signed'(raw));
      if (v > XB'(WMAX)) return WMAX;
      if (v < XB'(WMIN)) return WMIN;
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] clamp(input logic signed [W:0] s);
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      return clamp((W+1)'(a) + (W+1)'(b));
   endfunction

   function automatic logic signed [W-1:0] sat_abs(input logic signed [W-1:0] a);
      if (a == WMIN) return WMAX;
      return (a < 0) ? -a : a;
   endfunction

   logic [3:0]                        state_ff, state_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [1:0]                        comp_ff, comp_in;
   logic                              tbox_ff, tbox_in;
   logic [1:0]                        tidx_ff, tidx_in;
   logic [obb_pkg::AXIS_BITS-1:0]     axis_ff, axis_in;
   logic signed [W-1:0]               diff_ff [3];
   logic signed [W-1:0]               l_ff [3];
   logic signed [W-1:0]               ext_ff [3];
   logic signed [W-1:0]               ax_ff [3];
   logic signed [W-1:0]               scaled_ff [3];
   logic signed [W-1:0]               dot_ff;
   logic signed [W-1:0]               racc_ff [2];
   logic                              rsp_valid_ff;
   logic                              rsp_overlap_ff;
   logic [obb_pkg::AXIS_BITS-1:0]     rsp_axis_ff;
   logic                              res_overlap_ff, res_overlap_in;
   logic [obb_pkg::AXIS_BITS-1:0]     res_axis_ff, res_axis_in;

   logic                              req_accept;
   logic                              wr_en;
   logic [3*W-1:0]                    wr_data;
   logic [obb_pkg::SLOT_BITS-1:0]     rd_addr_a;
   logic [obb_pkg::SLOT_BITS-1:0]     rd_addr_b;
   logic [3*W-1:0]                    rd_data_a;
   logic [3*W-1:0]                    rd_data_b;
   logic signed [W-1:0]               mul_a;
   logic signed [W-1:0]               mul_b;
   logic signed [W-1:0]               mul_res;
   logic signed [W-1:0]               r0;
   logic signed [W-1:0]               rsum;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && (req_slot < obb_pkg::SLOT_BITS'(obb_pkg::NUM_SLOTS));
   assign wr_data    = {load_word(req_vec_z), load_word(req_vec_y), load_word(req_vec_x)};

   always_comb begin
      rd_addr_a = obb_pkg::SLOT_CENTER_A;
      rd_addr_b = obb_pkg::SLOT_CENTER_B;
      if (state_ff == S_RDL) begin
         rd_addr_a = (axis_ff < 3'd3) ? obb_pkg::SLOT_AXIS_A + obb_pkg::SLOT_BITS'(axis_ff)
                                      : obb_pkg::SLOT_AXIS_B
                                        + obb_pkg::SLOT_BITS'(axis_ff - 3'd3);
      end else if (state_ff == S_RDT) begin
         rd_addr_a = tbox_ff ? obb_pkg::SLOT_EXT_B : obb_pkg::SLOT_EXT_A;
         rd_addr_b = (tbox_ff ? obb_pkg::SLOT_AXIS_B : obb_pkg::SLOT_AXIS_A)
                     + obb_pkg::SLOT_BITS'(tidx_ff);
      end
   end

   obb_row_store #(.WORD_BITS(W)) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (req_slot),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      unique case (phase_ff)
         PH_SCALE: begin
            mul_a = ext_ff[tidx_ff];
            mul_b = ax_ff[comp_ff];
         end
         PH_DOT: begin
            mul_a = scaled_ff[comp_ff];
            mul_b = l_ff[comp_ff];
         end
         default: begin
            mul_a = diff_ff[comp_ff];
            mul_b = l_ff[comp_ff];
         end
      endcase
   end

   obb_fx_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res)
   );

   assign r0   = sat_abs(dot_ff);
   assign rsum = sat_add(racc_ff[0], racc_ff[1]);

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      comp_in        = comp_ff;
      tbox_in        = tbox_ff;
      tidx_in        = tidx_ff;
      axis_in        = axis_ff;
      res_overlap_in = res_overlap_ff;
      res_axis_in    = res_axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_last) state_in = S_RDDIFF;
         end
         S_RDDIFF: state_in = S_DIFF;
         S_DIFF: begin
            axis_in  = '0;
            state_in = S_RDL;
         end
         S_RDL: state_in = S_LATL;
         S_LATL: begin
            tbox_in  = 1'b0;
            tidx_in  = 2'd0;
            state_in = S_RDT;
         end
         S_RDT: state_in = S_LATT;
         S_LATT: begin
            phase_in = PH_SCALE;
            comp_in  = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: state_in = S_WB;
         S_WB: begin
            if (comp_ff == 2'd2) begin
               comp_in = 2'd0;
               unique case (phase_ff)
                  PH_SCALE: begin
                     phase_in = PH_DOT;
                     state_in = S_MUL;
                  end
                  PH_DOT:  state_in = S_ACC;
                  default: state_in = S_CMP;
               endcase
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_ACC: begin
            if (tbox_ff && tidx_ff == 2'd2) begin
               phase_in = PH_DIFF;
               comp_in  = 2'd0;
               state_in = S_MUL;
            end else if (tidx_ff == 2'd2) begin
               tbox_in  = 1'b1;
               tidx_in  = 2'd0;
               state_in = S_RDT;
            end else begin
               tidx_in  = tidx_ff + 2'd1;
               state_in = S_RDT;
            end
         end
         S_CMP: begin
            if (r0 > rsum) begin
               res_overlap_in = 1'b0;
               res_axis_in    = axis_ff;
               state_in       = S_DONE;
            end else if (axis_ff == AXIS_LAST) begin
               res_overlap_in = 1'b1;
               res_axis_in    = AXIS_NONE;
               state_in       = S_DONE;
            end else begin
               axis_in  = axis_ff + 3'd1;
               state_in = S_RDL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff       <= phase_in;
      comp_ff        <= comp_in;
      tbox_ff        <= tbox_in;
      tidx_ff        <= tidx_in;
      axis_ff        <= axis_in;
      res_overlap_ff <= res_overlap_in;
      res_axis_ff    <= res_axis_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_overlap_ff <= res_overlap_ff;
         rsp_axis_ff    <= res_axis_ff;
      end
      unique case (state_ff)
         S_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               diff_ff[c] <= clamp((W+1)'(signed'(rd_data_a[c*W +: W]))
                                   - (W+1)'(signed'(rd_data_b[c*W +: W])));
            end
         end
         S_LATL: begin
            for (int c = 0; c < 3; c++) l_ff[c] <= signed'(rd_data_a[c*W +: W]);
            racc_ff[0] <= '0;
            racc_ff[1] <= '0;
         end
         S_LATT: begin
            for (int c = 0; c < 3; c++) begin
               ext_ff[c] <= signed'(rd_data_a[c*W +: W]);
               ax_ff[c]  <= signed'(rd_data_b[c*W +: W]);
            end
         end
         S_WB: begin
            if (phase_ff == PH_SCALE) begin
               scaled_ff[comp_ff] <= mul_res;
            end else begin
               dot_ff <= sat_add(dot_ff, mul_res);
            end
            if (comp_ff == 2'd2 && phase_ff == PH_SCALE) dot_ff <= '0;
         end
         S_ACC: begin
            racc_ff[tbox_ff] <= sat_add(racc_ff[tbox_ff], sat_abs(dot_ff));
            dot_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_overlap         = rsp_overlap_ff;
   assign rsp_separating_axis = rsp_axis_ff;

`ifndef NO_ASSERTIONS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("Input not stalled while the test runs.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("Result appeared without a finished test.");

   a_overlap_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_overlap_ff) |-> (rsp_axis_ff == AXIS_NONE))
      else $error("Overlap reported with a separating axis.");

   a_sep_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_overlap_ff) |-> (rsp_axis_ff < AXIS_NONE))
      else $error("Separation reported without a valid axis.");
`endif

endmodule

`default_nettype wire
